// ----- src/hav_pkg.sv -----
// Shared constants, CORDIC tables and fixed-point formats for the haversine distance pipeline.
package hav_pkg;

  localparam int ANGLE_FRAC_BITS = 30;
  localparam int CORDIC_ITERS    = ANGLE_FRAC_BITS + 2;
  localparam int CW              = 34;

  localparam logic signed [CW-1:0] ONE_Q = CW'(64'd1 << ANGLE_FRAC_BITS);

  // Angle reduction in degrees * 2^17
  localparam int ANG_W = 28;
  localparam logic signed [ANG_W-1:0] HALF_TURN    = ANG_W'(180 * (1 << 17));
  localparam logic signed [ANG_W-1:0] FULL_TURN    = ANG_W'(2 * 180 * (1 << 17));
  localparam logic signed [ANG_W-1:0] QUARTER_TURN = ANG_W'(90 * (1 << 17));
  localparam int MAG_W = 24;

  // floor(pi * 2^60 / 180), split into two partial products
  localparam logic [54:0] DEG2RAD  = 55'd20122276272436452;
  localparam int DR_SPLIT          = 27;
  localparam logic [27:0] DR_HI    = DEG2RAD[54:27];
  localparam logic [26:0] DR_LO    = DEG2RAD[26:0];
  localparam int DR_SHIFT          = 77 - ANGLE_FRAC_BITS;
  localparam int PH_W              = MAG_W + 28;
  localparam int PL_W              = MAG_W + 27;

  // Square root
  localparam int SQ_IN_W  = 61;
  localparam int SQ_RW    = 62;
  localparam int SQ_OUT_W = 31;
  localparam int SQ_STEPS = 31;
  localparam int SQ_SHIFT = (59 - ANGLE_FRAC_BITS) & ~1;

  localparam int OUT_W     = 18;
  localparam int PROD_W    = 47;
  localparam int IN_TDATA_W  = 104;
  localparam int OUT_TDATA_W = 24;

  localparam int PIPE_LAT = 3 + CORDIC_ITERS + 3 + SQ_STEPS + CORDIC_ITERS + 2;

  // atan(2^-i) in Q30, rounded to nearest
  function automatic logic signed [CW-1:0] atan_q(input int i);
    logic signed [CW-1:0] t;
    unique case (i)
      0: t = CW'(843314857);
      1: t = CW'(497837829);
      2: t = CW'(263043837);
      3: t = CW'(133525159);
      4: t = CW'(67021687);
      5: t = CW'(33543516);
      6: t = CW'(16775851);
      7: t = CW'(8388437);
      8: t = CW'(4194283);
      9: t = CW'(2097149);
      default: t = (i >= ANGLE_FRAC_BITS) ? CW'(1) : CW'(64'd1 << (ANGLE_FRAC_BITS - i));
    endcase
    return t;
  endfunction

  // CORDIC gain squared, built the same way as the datapath expects it
  function automatic logic [63:0] gain_sq();
    logic [63:0] g;
    g = 64'd1 << ANGLE_FRAC_BITS;
    for (int i = 0; i < CORDIC_ITERS; i++) begin
      g = g + (g >> (2 * i));
    end
    return g;
  endfunction

  function automatic logic [63:0] gain_quad();
    logic [127:0] p;
    p = 128'(gain_sq()) * 128'(gain_sq());
    return 64'(p >> ANGLE_FRAC_BITS);
  endfunction

  localparam logic [31:0] CORDIC_G  = 32'(gain_sq());
  localparam logic [32:0] CORDIC_G2 = 33'(gain_quad());

endpackage

// ----- src/haversine_great_circle_distance.sv -----
// Top level of the haversine great-circle distance pipeline.
//
// Takes one word per clock: two points as signed latitude/longitude in degrees * 2^16, and
// returns the great-circle distance in whole kilometres for a sphere of radius radius_km
// (reset 6371), truncated, with 262143 as the largest value. Every input word yields exactly
// one output word, in input order, after passing through every stage. The pipeline is fully
// registered: angle reduction and degree-to-radian scaling (3 stages), four parallel
// rotation CORDICs for cos(lat1), cos(lat2), sin(dlat/2), sin(dlon/2) (32 stages), the
// haversine products and clamp (3 stages), two parallel bit-per-stage square roots
// (31 stages), a vectoring CORDIC for the arctangent (32 stages), and the radius scale and
// output register (2 stages). Sustained rate is one word per cycle. When m_axis_tready is
// low with a word waiting at the output, the whole pipeline holds; s_axis_tready follows.
// Write cfg_wdata into the radius with cfg_wen only while the pipeline is empty.
module haversine_great_circle_distance (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_wen,
  input  logic [15:0]                        cfg_wdata,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // [23:0] first_lat, [48:24] first_lon, [72:49] second_lat, [97:73] second_lon, rest zero
  input  logic [hav_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // [17:0] distance_km, rest zero
  output logic [hav_pkg::OUT_TDATA_W-1:0]    m_axis_tdata
);

  localparam int CW = hav_pkg::CW;
  localparam int F  = hav_pkg::ANGLE_FRAC_BITS;
  localparam int N  = hav_pkg::CORDIC_ITERS;
  localparam int L  = hav_pkg::PIPE_LAT;

  logic          adv;
  logic [L-1:0]  vld;
  logic [15:0]   radius_km;

  // Advance everything whenever the output slot is free or being taken
  assign adv           = !vld[L-1] || m_axis_tready;
  assign s_axis_tready = adv;
  assign m_axis_tvalid = vld[L-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[L-2:0], s_axis_tvalid};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      radius_km <= 16'd6371;
    end else if (cfg_wen) begin
      radius_km <= cfg_wdata;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: form the four angles in degrees * 2^17, wrap and fold into +-90 deg
  // ---------------------------------------------------------------------------
  logic signed [23:0] lat1, lat2;
  logic signed [24:0] lon1, lon2;
  logic signed [26:0] ang [4];

  assign lat1 = s_axis_tdata[23:0];
  assign lon1 = s_axis_tdata[48:24];
  assign lat2 = s_axis_tdata[72:49];
  assign lon2 = s_axis_tdata[97:73];

  assign ang[0] = 27'(lat1) <<< 1;
  assign ang[1] = 27'(lat2) <<< 1;
  assign ang[2] = 27'(lat2) - 27'(lat1);
  assign ang[3] = 27'(lon2) - 27'(lon1);

  logic [hav_pkg::MAG_W-1:0] s1_mag  [4];
  logic                      s1_neg  [4];
  logic                      s1_flip [4];

  always_comb begin
    logic signed [hav_pkg::ANG_W-1:0] r;
    logic                             fl;
    for (int k = 0; k < 4; k++) begin
      r  = hav_pkg::ANG_W'(ang[k]);
      fl = 1'b0;
      if (r >= hav_pkg::HALF_TURN) begin
        r = r - hav_pkg::FULL_TURN;
      end else if (r < -hav_pkg::HALF_TURN) begin
        r = r + hav_pkg::FULL_TURN;
      end
      // fold into the right half plane; cosine changes sign
      if (r > hav_pkg::QUARTER_TURN) begin
        r  = hav_pkg::HALF_TURN - r;
        fl = 1'b1;
      end else if (r < -hav_pkg::QUARTER_TURN) begin
        r  = -hav_pkg::HALF_TURN - r;
        fl = 1'b1;
      end
      s1_neg[k]  = r[hav_pkg::ANG_W-1];
      s1_mag[k]  = hav_pkg::MAG_W'(r[hav_pkg::ANG_W-1] ? -r : r);
      s1_flip[k] = fl;
    end
  end

  logic [hav_pkg::MAG_W-1:0] p1_mag  [4];
  logic                      p1_neg  [4];
  logic                      p1_flip [4];

  always_ff @(posedge clk) begin
    if (adv) begin
      p1_mag  <= s1_mag;
      p1_neg  <= s1_neg;
      p1_flip <= s1_flip;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: degree to radian scale, split into two partial products
  // ---------------------------------------------------------------------------
  logic [hav_pkg::PH_W-1:0] p2_ph   [4];
  logic [hav_pkg::PL_W-1:0] p2_pl   [4];
  logic                     p2_neg  [4];
  logic                     p2_flip [4];

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 4; k++) begin
        p2_ph[k] <= hav_pkg::PH_W'(p1_mag[k]) * hav_pkg::PH_W'(hav_pkg::DR_HI);
        p2_pl[k] <= hav_pkg::PL_W'(p1_mag[k]) * hav_pkg::PL_W'(hav_pkg::DR_LO);
      end
      p2_neg  <= p1_neg;
      p2_flip <= p1_flip;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 3: combine, truncate toward zero, restore the sign
  // ---------------------------------------------------------------------------
  logic signed [CW-1:0] s3_z [4];

  always_comb begin
    logic [79:0] zsum;
    logic [30:0] zm;
    for (int k = 0; k < 4; k++) begin
      zsum    = (80'(p2_ph[k]) << hav_pkg::DR_SPLIT) + 80'(p2_pl[k]);
      zm      = 31'(zsum >> hav_pkg::DR_SHIFT);
      s3_z[k] = p2_neg[k] ? -signed'(CW'(zm)) : signed'(CW'(zm));
    end
  end

  logic signed [CW-1:0] p3_z    [4];
  logic                 p3_flip [4];

  always_ff @(posedge clk) begin
    if (adv) begin
      p3_z    <= s3_z;
      p3_flip <= p2_flip;
    end
  end

  // ---------------------------------------------------------------------------
  // Rotation CORDICs: lane 0 cos(lat1), lane 1 cos(lat2),
  // lane 2 sin(dlat/2), lane 3 sin(dlon/2), all scaled by the gain K
  // ---------------------------------------------------------------------------
  logic signed [CW-1:0] rot_kc [4];
  logic signed [CW-1:0] rot_ks [4];

  for (genvar k = 0; k < 4; k++) begin : g_rot
    hav_rot u_rot (
      .clk     (clk),
      .en      (adv),
      .z_in    (p3_z[k]),
      .flip_in (p3_flip[k]),
      .kc      (rot_kc[k]),
      .ks      (rot_ks[k])
    );
  end

  // ---------------------------------------------------------------------------
  // Haversine products: squares and the cosine product
  // ---------------------------------------------------------------------------
  logic [30:0] c1m, c2m, sh1m, sh2m;
  logic [61:0] sq1_full, sq2_full, cc_full;

  assign c1m  = 31'(rot_kc[0][CW-1] ? -rot_kc[0] : rot_kc[0]);
  assign c2m  = 31'(rot_kc[1][CW-1] ? -rot_kc[1] : rot_kc[1]);
  assign sh1m = 31'(rot_ks[2][CW-1] ? -rot_ks[2] : rot_ks[2]);
  assign sh2m = 31'(rot_ks[3][CW-1] ? -rot_ks[3] : rot_ks[3]);

  assign sq1_full = 62'(sh1m) * 62'(sh1m);
  assign sq2_full = 62'(sh2m) * 62'(sh2m);
  assign cc_full  = 62'(c1m) * 62'(c2m);

  logic [31:0] m1_sq1, m1_sq2, m1_cc;
  logic        m1_ccn;

  always_ff @(posedge clk) begin
    if (adv) begin
      m1_sq1 <= 32'(sq1_full >> F);
      m1_sq2 <= 32'(sq2_full >> F);
      m1_cc  <= 32'(cc_full >> F);
      m1_ccn <= rot_kc[0][CW-1] ^ rot_kc[1][CW-1];
    end
  end

  logic [63:0] t1_full, t2_full;
  logic [33:0] t2m;

  assign t1_full = 64'(hav_pkg::CORDIC_G) * 64'(m1_sq1);
  assign t2_full = 64'(m1_cc) * 64'(m1_sq2);
  assign t2m     = 34'(t2_full >> F);

  logic        [33:0] m2_t1;
  logic signed [35:0] m2_t2;

  always_ff @(posedge clk) begin
    if (adv) begin
      m2_t1 <= 34'(t1_full >> F);
      m2_t2 <= m1_ccn ? -signed'(36'(t2m)) : signed'(36'(t2m));
    end
  end

  // ---------------------------------------------------------------------------
  // Clamp a into [0, K^4], form 1 - a, pre-shift both for the square roots
  // ---------------------------------------------------------------------------
  logic signed [36:0] asum;
  logic        [32:0] aval, bval;

  assign asum = signed'(37'(m2_t1)) + 37'(m2_t2);

  always_comb begin
    if (asum[36]) begin
      aval = '0;
    end else if (36'(asum) > 36'(hav_pkg::CORDIC_G2)) begin
      aval = hav_pkg::CORDIC_G2;
    end else begin
      aval = 33'(asum);
    end
    bval = hav_pkg::CORDIC_G2 - aval;
  end

  logic [hav_pkg::SQ_IN_W-1:0] a_sq, b_sq;

  always_ff @(posedge clk) begin
    if (adv) begin
      a_sq <= hav_pkg::SQ_IN_W'(aval) << hav_pkg::SQ_SHIFT;
      b_sq <= hav_pkg::SQ_IN_W'(bval) << hav_pkg::SQ_SHIFT;
    end
  end

  logic [hav_pkg::SQ_OUT_W-1:0] root_a, root_b;

  hav_isqrt u_sqrt_a (
    .clk  (clk),
    .en   (adv),
    .v_in (a_sq),
    .root (root_a)
  );

  hav_isqrt u_sqrt_b (
    .clk  (clk),
    .en   (adv),
    .v_in (b_sq),
    .root (root_b)
  );

  // ---------------------------------------------------------------------------
  // Vectoring CORDIC: half central angle = atan2(sqrt(a), sqrt(1 - a))
  // ---------------------------------------------------------------------------
  logic signed [CW-1:0] vx [N-1];
  logic signed [CW-1:0] vy [N-1];
  logic signed [CW-1:0] vz [N];

  for (genvar j = 0; j < N; j++) begin : g_vec
    logic signed [CW-1:0] xc, yc, zc, xn, yn, zn;

    if (j == 0) begin : g_src
      assign xc = signed'(CW'(root_b));
      assign yc = signed'(CW'(root_a));
      assign zc = '0;
    end else begin : g_chain
      assign xc = vx[j-1];
      assign yc = vy[j-1];
      assign zc = vz[j-1];
    end

    always_comb begin
      if (!yc[CW-1] && (yc != '0)) begin
        xn = xc + (yc >>> j);
        yn = yc - (xc >>> j);
        zn = zc + hav_pkg::atan_q(j);
      end else begin
        xn = xc - (yc >>> j);
        yn = yc + (xc >>> j);
        zn = zc - hav_pkg::atan_q(j);
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        vz[j] <= zn;
      end
    end

    if (j < N - 1) begin : g_xy
      always_ff @(posedge clk) begin
        if (adv) begin
          vx[j] <= xn;
          vy[j] <= yn;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Scale by the radius; 2*z*R >> F never exceeds the 18-bit field
  // ---------------------------------------------------------------------------
  logic [30:0]                zpos;
  logic [hav_pkg::PROD_W-1:0] d_prod;
  logic [hav_pkg::OUT_W-1:0]  dist_km;

  // drop a negative angle left by rounding
  assign zpos = vz[N-1][CW-1] ? '0 : vz[N-1][30:0];

  always_ff @(posedge clk) begin
    if (adv) begin
      d_prod  <= hav_pkg::PROD_W'(zpos) * hav_pkg::PROD_W'(radius_km);
      dist_km <= hav_pkg::OUT_W'(d_prod >> (F - 1));
    end
  end

  assign m_axis_tdata = {(hav_pkg::OUT_TDATA_W - hav_pkg::OUT_W)'(0), dist_km};

endmodule

// ----- src/hav_rot.sv -----
// Pipelined rotation-mode CORDIC: one iteration per register stage, gain left in.
module hav_rot (
  input  logic                          clk,
  input  logic                          en,
  input  logic signed [hav_pkg::CW-1:0] z_in,
  input  logic                          flip_in,
  output logic signed [hav_pkg::CW-1:0] kc,
  output logic signed [hav_pkg::CW-1:0] ks
);

  localparam int N = hav_pkg::CORDIC_ITERS;

  logic signed [hav_pkg::CW-1:0] xr [N-1];
  logic signed [hav_pkg::CW-1:0] yr [N-1];
  logic signed [hav_pkg::CW-1:0] zr [N-1];
  logic                          fr [N-1];

  for (genvar j = 0; j < N; j++) begin : g_it
    logic signed [hav_pkg::CW-1:0] xc, yc, zc, xn, yn, zn;
    logic                          fc;

    if (j == 0) begin : g_src
      assign xc = hav_pkg::ONE_Q;
      assign yc = '0;
      assign zc = z_in;
      assign fc = flip_in;
    end else begin : g_chain
      assign xc = xr[j-1];
      assign yc = yr[j-1];
      assign zc = zr[j-1];
      assign fc = fr[j-1];
    end

    always_comb begin
      if (!zc[hav_pkg::CW-1]) begin
        xn = xc - (yc >>> j);
        yn = yc + (xc >>> j);
        zn = zc - hav_pkg::atan_q(j);
      end else begin
        xn = xc + (yc >>> j);
        yn = yc - (xc >>> j);
        zn = zc + hav_pkg::atan_q(j);
      end
    end

    if (j < N - 1) begin : g_mid
      always_ff @(posedge clk) begin
        if (en) begin
          xr[j] <= xn;
          yr[j] <= yn;
          zr[j] <= zn;
          fr[j] <= fc;
        end
      end
    end else begin : g_last
      // apply the quadrant fold on the way out
      always_ff @(posedge clk) begin
        if (en) begin
          kc <= fc ? -xn : xn;
          ks <= yn;
        end
      end
    end
  end

endmodule

// ----- src/hav_isqrt.sv -----
// Pipelined integer square root (floor), one result bit per register stage.
module hav_isqrt (
  input  logic                           clk,
  input  logic                           en,
  input  logic [hav_pkg::SQ_IN_W-1:0]    v_in,
  output logic [hav_pkg::SQ_OUT_W-1:0]   root
);

  localparam int N  = hav_pkg::SQ_STEPS;
  localparam int RW = hav_pkg::SQ_RW;

  logic [RW-1:0] rem [N-1];
  logic [RW-1:0] rr  [N];

  for (genvar j = 0; j < N; j++) begin : g_st
    localparam logic [RW-1:0] BIT = RW'(1) << (2 * (N - 1 - j));
    logic [RW-1:0] remc, rc, remn, rn, trial;

    if (j == 0) begin : g_src
      assign remc = RW'(v_in);
      assign rc   = '0;
    end else begin : g_chain
      assign remc = rem[j-1];
      assign rc   = rr[j-1];
    end

    always_comb begin
      trial = rc + BIT;
      if (remc >= trial) begin
        remn = remc - trial;
        rn   = (rc >> 1) + BIT;
      end else begin
        remn = remc;
        rn   = rc >> 1;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rr[j] <= rn;
      end
    end

    if (j < N - 1) begin : g_rem
      always_ff @(posedge clk) begin
        if (en) begin
          rem[j] <= remn;
        end
      end
    end
  end

  assign root = rr[N-1][hav_pkg::SQ_OUT_W-1:0];

endmodule

// ----- dv/haversine_great_circle_distance_test.sv -----
// Self-checking stream test for the haversine great-circle distance pipeline.
module haversine_great_circle_distance_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FRAC = hav_pkg::ANGLE_FRAC_BITS;
  localparam int ITERS = FRAC + 2;
  localparam longint PI_Q60 = 64'sd3622009729038561421;
  localparam int DRAIN_CYCLES = hav_pkg::PIPE_LAT + 10;
  localparam longint LAT_MAX = 5898240;
  localparam longint LON_MAX = 11796480;
  localparam longint DEG = 65536;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_wen = 1'b0;
  logic [15:0] cfg_wdata = '0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [hav_pkg::IN_TDATA_W-1:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [hav_pkg::OUT_TDATA_W-1:0] m_axis_tdata;

  // Model copy of the radius register
  logic [15:0] radius_model = 16'd6371;
  // Distances still owed by the pipeline, oldest first
  logic [hav_pkg::OUT_TDATA_W-1:0] pending_distances[$];
  int errors = 0;
  // When set, neither side idles
  bit steady = 1'b0;
  longint atan_tab[ITERS];

  haversine_great_circle_distance uut (
    .clk(clk), .rst(rst), .cfg_wen(cfg_wen), .cfg_wdata(cfg_wdata),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // Product of two fixed-point values, shifted down and truncated toward zero
  function automatic longint mul_trunc(longint a, longint b, int s);
    logic [127:0] ua, ub, p;
    logic [63:0] r;
    bit neg;
    neg = (a < 0) != (b < 0);
    ua = (a < 0) ? 128'(-a) : 128'(a);
    ub = (b < 0) ? 128'(-b) : 128'(b);
    p = ua * ub;
    r = 64'(p >> s) & 64'h7fff_ffff_ffff_ffff;
    return neg ? -longint'(r) : longint'(r);
  endfunction

  function automatic longint arctan_entry(int i);
    longint sum, t;
    longint unsigned num;
    sum = 0;
    if (i == 0) begin
      sum = PI_Q60;
    end else begin
      for (int k = 0; i * (2 * k + 1) <= 62; k++) begin
        num = 64'd1 << (62 - i * (2 * k + 1));
        t = longint'(num / longint'(2 * k + 1));
        sum += (k % 2 == 1) ? -t : t;
      end
    end
    return (sum + (64'sd1 <<< (61 - FRAC))) >>> (62 - FRAC);
  endfunction

  // Scaled cosine and sine of an angle in degrees * 2^17 (gain left in)
  task automatic rotate_angle(input longint v, output longint kc, output longint ks);
    longint full, half, quarter, r, x, y, z, nx;
    bit flip;
    full = 360 * 131072;
    half = 180 * 131072;
    quarter = 90 * 131072;
    flip = 1'b0;
    r = v % full;
    if (r >= half) r -= full;
    if (r < -half) r += full;
    if (r > quarter) begin
      r = half - r;
      flip = 1'b1;
    end else if (r < -quarter) begin
      r = -half - r;
      flip = 1'b1;
    end
    z = mul_trunc(r, PI_Q60 / 180, 77 - FRAC);
    x = 64'sd1 <<< FRAC;
    y = 0;
    for (int i = 0; i < ITERS; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i); y = y + (x >>> i); z -= atan_tab[i];
      end else begin
        nx = x + (y >>> i); y = y - (x >>> i); z += atan_tab[i];
      end
      x = nx;
    end
    kc = flip ? -x : x;
    ks = y;
  endtask

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  task automatic predict_distance(input logic signed [23:0] lat1, input logic signed [24:0] lon1,
                                  input logic signed [23:0] lat2, input logic signed [24:0] lon2,
                                  output logic [17:0] dist_km);
    longint c1, s1, c2, s2, ch1, sh1, ch2, sh2, g, g2, t1, t2, a, b, x, y, z, nx, d;
    int sh;
    sh = (59 - FRAC) & ~1;
    rotate_angle(longint'(lat1) * 2, c1, s1);
    rotate_angle(longint'(lat2) * 2, c2, s2);
    rotate_angle(longint'(lat2) - longint'(lat1), ch1, sh1);
    rotate_angle(longint'(lon2) - longint'(lon1), ch2, sh2);
    g = 64'sd1 <<< FRAC;
    for (int i = 0; i < ITERS; i++)
      if (2 * i < 63) g += g >>> (2 * i);
    g2 = mul_trunc(g, g, FRAC);
    t1 = mul_trunc(g, mul_trunc(sh1, sh1, FRAC), FRAC);
    t2 = mul_trunc(mul_trunc(c1, c2, FRAC), mul_trunc(sh2, sh2, FRAC), FRAC);
    a = t1 + t2;
    // Clamp the haversine term into [0, 1] scaled by the gain
    if (a < 0) a = 0;
    if (a > g2) a = g2;
    b = g2 - a;
    x = longint'(int_sqrt(longint'(b) << sh));
    y = longint'(int_sqrt(longint'(a) << sh));
    z = 0;
    for (int i = 0; i < ITERS; i++) begin
      if (y > 0) begin
        nx = x + (y >>> i); y = y - (x >>> i); z += atan_tab[i];
      end else begin
        nx = x - (y >>> i); y = y + (x >>> i); z -= atan_tab[i];
      end
      x = nx;
    end
    if (z < 0) z = 0;
    d = (2 * z * longint'(radius_model)) >>> FRAC;
    if (d > 262143) d = 262143;
    dist_km = d[17:0];
  endtask

  // Random idle length: mostly none or short, a few long
  function automatic int pick_gap();
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Send one word of two points and queue its expected distance
  task automatic send_points(input logic signed [23:0] lat1, input logic signed [24:0] lon1,
                             input logic signed [23:0] lat2, input logic signed [24:0] lon2);
    int gap;
    logic [17:0] dist_km;
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      s_axis_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {6'b0, lon2, lat2, lon1, lat1};
    predict_distance(lat1, lon1, lat2, lon2, dist_km);
    // Hold the word until the pipeline takes it
    do @(posedge clk); while (!s_axis_tready);
    pending_distances.push_back({6'b0, dist_km});
  endtask

  task automatic release_input();
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
  endtask

  // Write the radius once the pipeline has drained
  task automatic set_radius(input logic [15:0] km);
    release_input();
    wait (pending_distances.size() == 0);
    repeat (DRAIN_CYCLES) @(negedge clk);
    cfg_wen <= 1'b1;
    cfg_wdata <= km;
    @(negedge clk);
    cfg_wen <= 1'b0;
    radius_model = km;
  endtask

  function automatic logic signed [23:0] deg_lat(longint d);
    return 24'(d * DEG);
  endfunction

  function automatic logic signed [24:0] deg_lon(longint d);
    return 25'(d * DEG);
  endfunction

  task automatic test_directed_points();
    send_points('0, '0, '0, '0);
    send_points(deg_lat(45), deg_lon(10), deg_lat(45), deg_lon(10));
    send_points('0, '0, '0, deg_lon(180));                       // antipodal on equator
    send_points(deg_lat(90), '0, deg_lat(-90), '0);              // pole to pole
    send_points(24'(LAT_MAX), 25'(LON_MAX), 24'(-LAT_MAX), 25'(-LON_MAX));
    send_points(24'(-LAT_MAX), 25'(-LON_MAX), 24'(LAT_MAX), 25'(LON_MAX));
    send_points(deg_lat(10), deg_lon(179), deg_lat(10), deg_lon(-179)); // across date line
    send_points(deg_lat(30), deg_lon(20), deg_lat(30), 25'(20 * DEG + 1)); // tiny step
    send_points(24'sd1, 25'sd0, 24'sd0, 25'sd1);
    send_points(deg_lat(90), deg_lon(45), deg_lat(90), deg_lon(-135));
    // Raw values outside the coordinate range wrap modulo a full turn
    send_points(24'h800000, 25'h1000000, 24'h7fffff, 25'h0ffffff);
    send_points(24'hffffff, 25'h1ffffff, 24'h000000, 25'h0000000);
    send_points(24'h7fffff, 25'h1000000, 24'h800000, 25'h0ffffff);
    send_points(deg_lat(51), deg_lon(0), deg_lat(40), deg_lon(-74));
    send_points(deg_lat(-33), deg_lon(151), deg_lat(35), deg_lon(139));
    send_points(deg_lat(89), deg_lon(-180), deg_lat(-89), deg_lon(0)); // near antipodal
  endtask

  task automatic send_random_points();
    int r;
    logic signed [23:0] lat1, lat2;
    logic signed [24:0] lon1, lon2;
    r = $urandom_range(0, 99);
    if (r < 12) begin
      // Full field width, including out-of-range codes
      lat1 = 24'($urandom); lon1 = 25'($urandom);
      lat2 = 24'($urandom); lon2 = 25'($urandom);
    end else begin
      lat1 = 24'(longint'($urandom_range(0, 2 * LAT_MAX)) - LAT_MAX);
      lon1 = 25'(longint'($urandom_range(0, 2 * LON_MAX)) - LON_MAX);
      if (r < 30) begin
        // Nearby second point
        lat2 = lat1 + 24'(int'($urandom_range(0, 2000)) - 1000);
        lon2 = lon1 + 25'(int'($urandom_range(0, 2000)) - 1000);
      end else if (r < 40) begin
        // Near the antipode
        lat2 = -lat1 + 24'(int'($urandom_range(0, 200)) - 100);
        lon2 = lon1 + ((lon1 < 0) ? 25'(180 * DEG) : -25'(180 * DEG));
      end else begin
        lat2 = 24'(longint'($urandom_range(0, 2 * LAT_MAX)) - LAT_MAX);
        lon2 = 25'(longint'($urandom_range(0, 2 * LON_MAX)) - LON_MAX);
      end
    end
    send_points(lat1, lon1, lat2, lon2);
  endtask

  task automatic test_random_points(input int count);
    for (int n = 0; n < count; n++) begin
      // Run a stretch with no idling now and then
      if (n % 100 == 0) steady = ($urandom_range(0, 3) == 0);
      send_random_points();
    end
    steady = 1'b0;
  endtask

  task automatic test_radius_settings();
    logic [15:0] radii[5];
    radii = '{16'd1, 16'd65535, 16'd0, 16'($urandom_range(1, 65535)), 16'd6371};
    foreach (radii[k]) begin
      set_radius(radii[k]);
      send_points('0, '0, '0, deg_lon(180));
      send_points(deg_lat(90), '0, deg_lat(-90), '0);
      test_random_points(30);
    end
  endtask

  // Output side back-pressure
  initial begin
    int stall_left;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (stall_left > 0 && !steady) begin
        m_axis_tready <= 1'b0;
        stall_left--;
      end else begin
        m_axis_tready <= 1'b1;
        stall_left = 0;
        if ($urandom_range(0, 99) < 12)
          stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                    : $urandom_range(1, 3);
      end
    end
  end

  // Compare each delivered word with the oldest expectation
  initial begin
    logic [hav_pkg::OUT_TDATA_W-1:0] want;
    forever begin
      @(posedge clk);
      if (!rst && m_axis_tvalid && m_axis_tready) begin
        if (pending_distances.size() == 0) begin
          $display("%0t: unexpected word, expected none, actual distance_km %0d",
                   $realtime, m_axis_tdata[17:0]);
          errors++;
        end else begin
          want = pending_distances.pop_front();
          if (m_axis_tdata !== want) begin
            $display("%0t: distance_km expected %0d, actual %0d (tdata %h vs %h)",
                     $realtime, want[17:0], m_axis_tdata[17:0], want, m_axis_tdata);
            errors++;
          end
        end
      end
    end
  end

  initial begin
    #20ms;
    $display("haversine_great_circle_distance: mismatch");
    $finish;
  end

  initial begin
    for (int i = 0; i < ITERS; i++) atan_tab[i] = arctan_entry(i);
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_directed_points();
    test_random_points(420);
    test_radius_settings();
    release_input();
    wait (pending_distances.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0 && pending_distances.size() == 0)
      $display("haversine_great_circle_distance: match");
    else
      $display("haversine_great_circle_distance: mismatch");
    $finish;
  end

endmodule

// ----- sim.f -----
src/hav_pkg.sv
src/hav_rot.sv
src/hav_isqrt.sv
src/haversine_great_circle_distance.sv
dv/haversine_great_circle_distance_test.sv
